[design/zpkc_pkg.sv]
package zpkc_pkg;

    // Pixel and coefficient formats
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int TAPS       = 3;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = TAPS * COEF_W;
    localparam int WIDTH_CFG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = HEIGHT_W + 1;

    // Datapath widths
    localparam int LINE_W     = 2 * PIX_W;
    localparam int TAP_W      = PIX_W + COEF_W + 1 - FRAC_W;
    localparam int ROW_SUM_W  = TAP_W + 2;
    localparam int SUM_W      = ROW_SUM_W + 2;
    localparam int MAG_W      = 19;
    localparam int NORM_SUM_W = COEF_W + 4;
    localparam int DIV_STEPS  = MAG_W;

    // Reset values of the registers
    localparam logic [WIDTH_CFG_W-1:0] RST_WIDTH         = 11'd640;
    localparam logic [HEIGHT_W-1:0]    RST_HEIGHT        = 16'd480;
    localparam logic [CFG_DATA_W-1:0]  RST_KERNEL_TOP    = '0;
    localparam logic [CFG_DATA_W-1:0]  RST_KERNEL_MIDDLE = 48'd256;
    localparam logic [CFG_DATA_W-1:0]  RST_KERNEL_BOTTOM = '0;

    // 1.0 in Q8.8 at the width of the coefficient sum
    localparam logic signed [NORM_SUM_W-1:0] NORM_ONE = 20'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_idx;

    // Control that travels with a result through the pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    // Partial remainder and dividend/quotient shift word of the divider
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] dq;
    } t_div_word;

endpackage

[design/zpkc_pix_if.sv]
interface zpkc_pix_if
    import zpkc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             operation;

    modport source (output valid, output pixel, output operation, input ready);
    modport sink   (input valid, input pixel, input operation, output ready);
endinterface

[design/zpkc_res_if.sv]
interface zpkc_res_if
    import zpkc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] filtered;
    logic             overflow;
    logic             frame_last;

    modport source (output valid, output filtered, output overflow, output frame_last,
                    input ready);
    modport sink   (input valid, input filtered, input overflow, input frame_last,
                    output ready);
endinterface

[design/zpkc_cfg_if.sv]
interface zpkc_cfg_if
    import zpkc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/zpkc_tap_cell.sv]
module zpkc_tap_cell
    import zpkc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  logic [PIX_W-1:0]         i_pix,
    input  logic                     i_calc,
    input  logic                     i_use,
    input  logic signed [COEF_W-1:0] i_coef,
    output logic [PIX_W-1:0]         o_pix,
    output logic signed [TAP_W-1:0]  o_tap
);

    logic [PIX_W-1:0]                r_pix;
    logic signed [TAP_W-1:0]         r_tap;
    logic signed [PIX_W+COEF_W:0]    w_prod;
    logic signed [PIX_W+COEF_W:0]    w_adj;

    // Window pixel: take the neighbor's value on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    // Tap product, truncated toward zero to an integer
    assign w_prod = $signed({1'b0, r_pix}) * i_coef;
    assign w_adj  = w_prod + $signed({{(PIX_W + COEF_W + 1 - FRAC_W){1'b0}},
                                      {FRAC_W{w_prod[PIX_W+COEF_W]}}});

    // Register the product; drop taps that fall outside the frame
    always_ff @(posedge i_clk) begin
        if (i_calc) begin
            r_tap <= i_use ? w_adj[PIX_W+COEF_W:FRAC_W] : '0;
        end
    end

    assign o_pix = r_pix;
    assign o_tap = r_tap;

endmodule

[design/zpkc_div_cell.sv]
module zpkc_div_cell
    import zpkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_tag             i_tag,
    input  t_div_word        i_word,
    input  logic [MAG_W-1:0] i_div,
    output t_tag             o_tag,
    output t_div_word        o_word
);

    t_tag             r_tag;
    t_div_word        r_word;
    logic [MAG_W:0]   w_sh;
    logic [MAG_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: bring in the next dividend bit, try the subtract
    assign w_sh   = {i_word.rem, i_word.dq[MAG_W-1]};
    assign w_diff = w_sh - {1'b0, i_div};
    assign w_ge   = w_sh >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.rem <= w_ge ? w_diff[MAG_W-1:0] : w_sh[MAG_W-1:0];
            r_word.dq  <= {i_word.dq[MAG_W-2:0], w_ge};
        end
    end

    assign o_tag  = r_tag;
    assign o_word = r_word;

endmodule

[design/zero_padded_kernel_convolution.sv]
// 3x3 zero-padded convolution over a raster stream of 8-bit grayscale pixels.
// Channels: i_pix takes pixels (operation 0) and, after the last pixel of a
// frame, image_width + 1 pad ticks (operation 1) that flush the last results.
// o_res gives one filtered pixel per frame pixel, frame_last on the final one.
// i_cfg writes image_width, image_height and the three Q8.8 kernel rows; it is
// always ready and is meant to be used while no item is in flight. A width or
// height write restarts the frame.
// Throughput: one item per clock while o_res keeps up. A result reaches the
// output register once the tick that completes its 3x3 window (image_width
// + 1 ticks after the pixel itself) has passed the window, product, row-sum
// and magnitude stages and the 19-step pipelined restoring divider that
// normalizes the sum. Reset: registers return to their defaults and a
// clearing pass zeroes the line store, during which i_pix is not ready.
// Stall: a finished result waits in the output register; the pipeline keeps
// moving while it carries no result behind it, and holds otherwise.
module zero_padded_kernel_convolution
    import zpkc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zpkc_pix_if.sink    i_pix,
    zpkc_res_if.source  o_res,
    zpkc_cfg_if.sink    i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > WIDTH_CFG_W) ? CW + 1 : WIDTH_CFG_W;

    // Configuration
    logic [WIDTH_CFG_W-1:0] r_cfg_width;
    logic [HEIGHT_W-1:0]    r_cfg_height;
    logic [CFG_DATA_W-1:0]  r_kernel [TAPS];
    logic                   w_cfg_wr;
    logic                   w_cfg_restart;
    logic [WW-1:0]          w_cfg_width_x;
    logic [WW-1:0]          w_eff_w;
    logic [ROW_W-1:0]       w_eff_h;

    // Norm
    logic signed [NORM_SUM_W-1:0] w_norm_sum;
    logic signed [NORM_SUM_W-1:0] w_norm_fix;
    logic [NORM_SUM_W-1:0]        w_norm_abs;
    logic [MAG_W-1:0]             r_norm_abs;

    // Stream position and input side
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic             w_en;
    logic             w_acc;
    logic             w_take;
    logic             w_in_frame;
    logic [PIX_W-1:0] w_pix_v;
    logic [WW-1:0]    w_col_x;
    logic [WW-1:0]    w_col_inc;
    logic             w_col_nz;
    logic             w_has_res;
    logic [ROW_W-1:0] w_rc;
    logic [WW-1:0]    w_cc;
    logic [TAPS-1:0]  w_row_ok;
    logic [TAPS-1:0]  w_col_ok;
    logic             w_last;

    // Line store clearing pass
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;

    // Line store: previous row in the high byte, the row before it in the low byte
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd;
    logic              w_mem_we;
    logic [CW-1:0]     w_mem_wa;
    logic [LINE_W-1:0] w_mem_wd;

    // Stage 1: line store read done, window update
    logic              r_s1_vld;
    logic              r_s1_res;
    logic              r_s1_last;
    logic [TAPS-1:0]   r_s1_row_ok;
    logic [TAPS-1:0]   r_s1_col_ok;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [CW-1:0]     r_s1_addr;
    logic              r_s1_fwd;
    logic [LINE_W-1:0] r_s1_fwd_data;
    logic [LINE_W-1:0] w_line;
    logic [PIX_W-1:0]  w_up;
    logic [PIX_W-1:0]  w_lo;
    logic              w_shift;

    // Stage 2..5: products, row sums, magnitude
    t_tag                        r_s2_tag;
    logic [TAPS-1:0]             r_s2_row_ok;
    logic [TAPS-1:0]             r_s2_col_ok;
    t_tag                        r_s3_tag;
    t_tag                        r_s4_tag;
    t_tag                        r_s5_tag;
    logic [PIX_W-1:0]            w_src [TAPS];
    logic [PIX_W-1:0]            w_cell_pix [TAPS][TAPS];
    logic signed [TAP_W-1:0]     w_cell_tap [TAPS][TAPS];
    logic signed [ROW_SUM_W-1:0] r_row_sum [TAPS];
    logic signed [SUM_W-1:0]     w_total;
    logic [SUM_W-1:0]            w_total_abs;
    logic [MAG_W-1:0]            r_mag;

    // Divider chain and output
    t_tag             w_div_tag [DIV_STEPS+1];
    t_div_word        w_div_word [DIV_STEPS+1];
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_filtered;
    logic             r_out_ovf;
    logic             r_out_last;

    // ------------------------------------------------------------------
    // Configuration registers
    assign i_cfg.ready   = 1'b1;
    assign w_cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign w_cfg_restart = w_cfg_wr && (i_cfg.index == CFG_IMAGE_WIDTH ||
                                        i_cfg.index == CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_kernel[0]  <= RST_KERNEL_TOP;
            r_kernel[1]  <= RST_KERNEL_MIDDLE;
            r_kernel[2]  <= RST_KERNEL_BOTTOM;
        end else if (w_cfg_wr) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg.data[WIDTH_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg.data[HEIGHT_W-1:0];
                CFG_KERNEL_TOP:    r_kernel[0]  <= i_cfg.data;
                CFG_KERNEL_MIDDLE: r_kernel[1]  <= i_cfg.data;
                CFG_KERNEL_BOTTOM: r_kernel[2]  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Effective frame size: zero means one, width saturates at the store depth
    assign w_cfg_width_x = WW'(r_cfg_width);

    always_comb begin
        if (w_cfg_width_x == '0) begin
            w_eff_w = WW'(1);
        end else if (w_cfg_width_x > WW'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = w_cfg_width_x;
        end
    end

    assign w_eff_h = (r_cfg_height == '0) ? ROW_W'(1) : ROW_W'(r_cfg_height);

    // Norm: sum of the nine coefficients, 1.0 when its integer part is zero
    always_comb begin
        w_norm_sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            for (int m = 0; m < TAPS; m++) begin
                w_norm_sum = w_norm_sum +
                    NORM_SUM_W'($signed(r_kernel[k][COEF_W*m +: COEF_W]));
            end
        end
    end

    assign w_norm_fix = (w_norm_sum < NORM_ONE && w_norm_sum > -NORM_ONE) ?
                        NORM_ONE : w_norm_sum;
    assign w_norm_abs = w_norm_fix[NORM_SUM_W-1] ? NORM_SUM_W'(-w_norm_fix) :
                        NORM_SUM_W'(w_norm_fix);

    always_ff @(posedge i_clk) begin
        r_norm_abs <= w_norm_abs[MAG_W-1:0];
    end

    // ------------------------------------------------------------------
    // Input transfer and stream position
    assign i_pix.ready = w_en && !r_clr_busy;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_in_frame  = r_row < w_eff_h;
    // pad ticks inside the frame are taken and dropped
    assign w_take      = w_acc && !(w_in_frame && i_pix.operation);
    assign w_pix_v     = w_in_frame ? i_pix.pixel : '0;

    assign w_col_x   = WW'(r_col);
    assign w_col_inc = w_col_x + WW'(1);
    assign w_col_nz  = r_col != '0;

    // Window centre lags the incoming tick by one row and one pixel
    assign w_has_res = w_col_nz ? (r_row >= ROW_W'(1)) : (r_row >= ROW_W'(2));
    assign w_rc      = w_col_nz ? r_row - ROW_W'(1) : r_row - ROW_W'(2);
    assign w_cc      = w_col_nz ? w_col_x - WW'(1) : w_eff_w - WW'(1);

    assign w_row_ok[0] = w_rc != '0;
    assign w_row_ok[1] = w_rc < w_eff_h;
    assign w_row_ok[2] = ({1'b0, w_rc} + (ROW_W + 1)'(1)) < {1'b0, w_eff_h};
    assign w_col_ok[0] = w_cc != '0;
    assign w_col_ok[1] = w_cc < w_eff_w;
    assign w_col_ok[2] = (w_cc + WW'(1)) < w_eff_w;

    assign w_last = (w_rc == w_eff_h - ROW_W'(1)) && (w_cc == w_eff_w - WW'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_take) begin
            if (w_has_res && w_last) begin
                n_col = '0;
                n_row = '0;
            end else if (w_col_inc >= w_eff_w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = w_col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass over the line store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Line store: read at transfer, written back from the stage 1 registers
    assign w_mem_we = r_clr_busy || (w_en && r_s1_vld);
    assign w_mem_wa = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign w_mem_wd = r_clr_busy ? '0 : {r_s1_pix, w_up};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_take) begin
            r_rd <= r_line_mem[r_col];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the tick and its window position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_res      <= w_has_res;
            r_s1_last     <= w_last;
            r_s1_row_ok   <= w_row_ok;
            r_s1_col_ok   <= w_col_ok;
            r_s1_pix      <= w_pix_v;
            r_s1_addr     <= r_col;
            // forward the write that lands in the same cycle as this read
            r_s1_fwd      <= r_s1_vld && (r_s1_addr == r_col);
            r_s1_fwd_data <= {r_s1_pix, w_up};
        end
    end

    assign w_line  = r_s1_fwd ? r_s1_fwd_data : r_rd;
    assign w_up    = w_line[LINE_W-1:PIX_W];
    assign w_lo    = w_line[PIX_W-1:0];
    assign w_shift = w_en && r_s1_vld;

    // New right column of the window: two rows back, one row back, current
    assign w_src[0] = w_lo;
    assign w_src[1] = w_up;
    assign w_src[2] = r_s1_pix;

    // Stage 2: window holds this tick's neighborhood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag <= '0;
        end else if (w_en) begin
            r_s2_tag.vld  <= r_s1_vld && r_s1_res;
            r_s2_tag.last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_row_ok <= r_s1_row_ok;
            r_s2_col_ok <= r_s1_col_ok;
        end
    end

    // Window cells: each row shifts left, products registered in the cells
    for (genvar k = 0; k < TAPS; k++) begin : g_row
        for (genvar m = 0; m < TAPS; m++) begin : g_col
            zpkc_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_pix   ((m == TAPS - 1) ? w_src[k] : w_cell_pix[k][(m + 1) % TAPS]),
                .i_calc  (w_en),
                .i_use   (r_s2_row_ok[k] && r_s2_col_ok[m]),
                .i_coef  ($signed(r_kernel[k][COEF_W*m +: COEF_W])),
                .o_pix   (w_cell_pix[k][m]),
                .o_tap   (w_cell_tap[k][m])
            );
        end
    end

    // Stage 3..5: products, row sums, magnitude of the total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_tag <= '0;
            r_s4_tag <= '0;
            r_s5_tag <= '0;
        end else if (w_en) begin
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
            r_s5_tag <= r_s4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < TAPS; k++) begin
                r_row_sum[k] <= ROW_SUM_W'(w_cell_tap[k][0]) +
                                ROW_SUM_W'(w_cell_tap[k][1]) +
                                ROW_SUM_W'(w_cell_tap[k][2]);
            end
            r_mag <= w_total_abs[MAG_W-1:0];
        end
    end

    assign w_total     = SUM_W'(r_row_sum[0]) + SUM_W'(r_row_sum[1]) +
                         SUM_W'(r_row_sum[2]);
    assign w_total_abs = w_total[SUM_W-1] ? SUM_W'(-w_total) : SUM_W'(w_total);

    // ------------------------------------------------------------------
    // Divider: (magnitude * 256) / norm, one quotient bit per cell.
    // The top dividend bits are preloaded: they stay below any norm.
    assign w_div_tag[0]       = r_s5_tag;
    assign w_div_word[0].rem  = MAG_W'(r_mag[MAG_W-1:MAG_W-FRAC_W]);
    assign w_div_word[0].dq   = {r_mag[MAG_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        zpkc_div_cell u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (w_div_tag[i]),
            .i_word  (w_div_word[i]),
            .i_div   (r_norm_abs),
            .o_tag   (w_div_tag[i+1]),
            .o_word  (w_div_word[i+1])
        );
    end

    // Advance unless a result would run into a full, stalled output register
    assign w_en = !(w_div_tag[DIV_STEPS].vld && r_out_vld && !o_res.ready);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && w_div_tag[DIV_STEPS].vld) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_div_tag[DIV_STEPS].vld) begin
            r_out_filtered <= w_div_word[DIV_STEPS].dq[PIX_W-1:0];
            r_out_ovf      <= |w_div_word[DIV_STEPS].dq[MAG_W-1:PIX_W];
            r_out_last     <= w_div_tag[DIV_STEPS].last;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.filtered   = r_out_filtered;
    assign o_res.overflow   = r_out_ovf;
    assign o_res.frame_last = r_out_last;

endmodule

[bench/tb_zero_padded_kernel_convolution.sv]
`timescale 1ns / 100ps

module tb_zero_padded_kernel_convolution;
    import zpkc_pkg::*;

    localparam int LINE_MAX     = 1024;
    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 4 * LINE_MAX + 2000;
    localparam int REPORT_MAX   = 10;
    localparam int IDLE_HEAVY   = 57;
    localparam int IDLE_BOTH    = 18;

    // Tick kinds on the pixel channel
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_PAD   = 1'b1;

    typedef struct {
        logic [PIX_W-1:0] filtered;
        logic             overflow;
        logic             frame_last;
    } t_pixel_result;

    logic clk;
    logic rst_n;

    zpkc_pix_if pix_if ();
    zpkc_res_if res_if ();
    zpkc_cfg_if cfg_if ();

    zero_padded_kernel_convolution #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_pix  (pix_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    // Filter model state
    logic [WIDTH_CFG_W-1:0] model_width;
    logic [HEIGHT_W-1:0]    model_height;
    logic [CFG_DATA_W-1:0]  model_kernel [3];
    logic [PIX_W-1:0]       row_delay1 [LINE_MAX];
    logic [PIX_W-1:0]       row_delay2 [LINE_MAX];
    logic [PIX_W-1:0]       tap_window [3][3];
    int                     col_pos;
    int                     row_pos;
    int                     norm_q88;

    t_pixel_result expected_pixels [$];
    int            mismatches;
    int            result_count;
    int            quiet_cycles;
    int            src_idle_pct;
    int            sink_stall_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int frame_width();
        int w;
        w = int'(model_width);
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int frame_height();
        return (model_height == '0) ? 1 : int'(model_height);
    endfunction

    function automatic int tap_coef(input int k, input int m);
        return int'($signed(model_kernel[k][16*m +: 16]));
    endfunction

    // Norm is the Q8.8 coefficient sum, 1.0 when its integer part is zero
    function automatic void refresh_norm();
        int k;
        int m;
        int n;
        n = 0;
        for (k = 0; k < 3; k++)
            for (m = 0; m < 3; m++)
                n += tap_coef(k, m);
        if (n > -256 && n < 256) n = 256;
        norm_q88 = n;
    endfunction

    // Advance the filter model by one accepted tick, queue the result it yields
    function automatic void convolve_tick(input logic [PIX_W-1:0] value, input logic op);
        int w;
        int h;
        int ci;
        int ri;
        int rc;
        int cc;
        int k;
        int m;
        int nr;
        int nc;
        int prod;
        int tap_total;
        int mag;
        int nabs;
        int quot;
        logic [PIX_W-1:0] v;
        t_pixel_result res;

        w  = frame_width();
        h  = frame_height();
        ci = col_pos;
        ri = row_pos;
        // drop pad ticks inside the frame
        if (ri < h && op == OP_PAD) return;
        v = (ri < h) ? value : '0;
        if (ci >= LINE_MAX) ci = LINE_MAX - 1;

        for (k = 0; k < 3; k++) begin
            tap_window[k][0] = tap_window[k][1];
            tap_window[k][1] = tap_window[k][2];
        end
        tap_window[0][2] = row_delay2[ci];
        tap_window[1][2] = row_delay1[ci];
        tap_window[2][2] = v;
        row_delay2[ci]   = row_delay1[ci];
        row_delay1[ci]   = v;

        // window centre trails the incoming tick by width + 1
        if (ci >= 1) begin
            rc = ri - 1;
            cc = ci - 1;
        end else begin
            rc = ri - 2;
            cc = w - 1;
        end

        col_pos = ci + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = ri + 1;
        end
        if (rc < 0) return;

        tap_total = 0;
        for (k = 0; k < 3; k++) begin
            nr = rc + k - 1;
            if (nr < 0 || nr >= h) continue;
            for (m = 0; m < 3; m++) begin
                nc = cc + m - 1;
                if (nc < 0 || nc >= w) continue;
                prod = int'(tap_window[k][m]) * tap_coef(k, m);
                tap_total += (prod >= 0) ? (prod / 256) : -((-prod) / 256);
            end
        end

        mag  = (tap_total < 0) ? -tap_total : tap_total;
        nabs = (norm_q88 < 0) ? -norm_q88 : norm_q88;
        quot = (mag * 256) / nabs;

        res.filtered   = quot[PIX_W-1:0];
        res.overflow   = (quot > 255);
        res.frame_last = (rc == h - 1) && (cc == w - 1);
        expected_pixels.push_back(res);
        if (res.frame_last) begin
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Styles: any bits, small signed, positive, negative
    function automatic logic [CFG_DATA_W-1:0] random_kernel_row(input int style);
        logic [CFG_DATA_W-1:0] row;
        logic [COEF_W-1:0]     c;
        int                    m;
        for (m = 0; m < 3; m++) begin
            case (style)
                0: c = COEF_W'($urandom);
                1: c = COEF_W'($urandom_range(1024) - 512);
                2: c = COEF_W'($urandom_range(1023));
                default: c = COEF_W'(-int'($urandom_range(1023)));
            endcase
            row[16*m +: 16] = c;
        end
        return row;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    task automatic set_idle_phase(input int phase);
        case (phase)
            0: begin src_idle_pct = 0;          sink_stall_pct = 0;          end
            1: begin src_idle_pct = IDLE_HEAVY; sink_stall_pct = 0;          end
            2: begin src_idle_pct = 0;          sink_stall_pct = IDLE_HEAVY; end
            default: begin src_idle_pct = IDLE_BOTH; sink_stall_pct = IDLE_BOTH; end
        endcase
    endtask

    // Send one tick; valid stays up after the transfer until the next call or a drain
    task automatic send_tick(input logic [PIX_W-1:0] value, input logic op);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.pixel     <= value;
        pix_if.operation <= op;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        convolve_tick(value, op);
    endtask

    // Stop sending, wait for every queued result, then let the pipeline empty
    task automatic drain_results();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                model_width = value[WIDTH_CFG_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                model_height = value[HEIGHT_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_KERNEL_TOP:    begin model_kernel[0] = value; refresh_norm(); end
            CFG_KERNEL_MIDDLE: begin model_kernel[1] = value; refresh_norm(); end
            CFG_KERNEL_BOTTOM: begin model_kernel[2] = value; refresh_norm(); end
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stream frame pixels then flush ticks; noisy adds dropped pads, pixel-valued
    // flush ticks and a mid-frame pause with an optional kernel rewrite
    task automatic stream_frame(input int pixel_ticks, input int flush_ticks,
                                input bit noisy, output int sent);
        int i;
        int pause_at;
        sent = 0;
        pause_at = (noisy && $urandom_range(7) == 0) ? $urandom_range(pixel_ticks - 1, 0) : -1;
        for (i = 0; i < pixel_ticks; i++) begin
            if (noisy && $urandom_range(24) == 0) send_tick(random_pixel(), OP_PAD);
            if (i == pause_at) begin
                drain_results();
                if ($urandom_range(1) == 1)
                    write_reg(CFG_KERNEL_MIDDLE, random_kernel_row($urandom_range(3)));
            end
            send_tick(random_pixel(), OP_PIXEL);
            sent++;
        end
        for (i = 0; i < flush_ticks; i++) begin
            send_tick(random_pixel(), (noisy && $urandom_range(3) == 0) ? OP_PIXEL : OP_PAD);
            sent++;
        end
    endtask

    // 1x1 frames from zero sizes, first with the reset kernel, then a centre tap
    task automatic test_degenerate_sizes();
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        send_tick(8'hA5, OP_PAD);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'h3C, OP_PIXEL);
        send_tick(8'h00, OP_PAD);
        drain_results();
        write_reg(CFG_KERNEL_MIDDLE, 48'h0000_0100_0000);
        send_tick(8'd200, OP_PIXEL);
        send_tick(8'h00, OP_PAD);
        send_tick(8'hFF, OP_PAD);
        drain_results();
    endtask

    // Extreme coefficients, truncation of negative products, pad inside the frame
    task automatic test_small_frame();
        write_reg(CFG_IMAGE_WIDTH, 48'd3);
        write_reg(CFG_IMAGE_HEIGHT, 48'd2);
        write_reg(CFG_KERNEL_TOP, 48'h8000_7FFF_0100);
        write_reg(CFG_KERNEL_MIDDLE, 48'hFF00_0200_8000);
        write_reg(CFG_KERNEL_BOTTOM, 48'hFFFF_FFFF_FFFF);
        send_tick(8'h00, OP_PIXEL);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'h01, OP_PIXEL);
        send_tick(8'h55, OP_PAD);
        send_tick(8'h80, OP_PIXEL);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'hFE, OP_PIXEL);
        send_tick(8'd77, OP_PIXEL);
        send_tick(8'h00, OP_PAD);
        send_tick(8'h00, OP_PAD);
        send_tick(8'hAA, OP_PAD);
        drain_results();
    endtask

    // Zero-sum kernel; a height write in mid-frame restarts the frame
    task automatic test_restart_and_flush();
        set_idle_phase(3);
        write_reg(CFG_IMAGE_WIDTH, 48'd2);
        write_reg(CFG_IMAGE_HEIGHT, 48'd2);
        write_reg(CFG_KERNEL_TOP, 48'h0000_FF00_0000);
        write_reg(CFG_KERNEL_MIDDLE, 48'hFF00_0400_FF00);
        write_reg(CFG_KERNEL_BOTTOM, 48'h0000_FF00_0000);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'h00, OP_PIXEL);
        send_tick(8'hFF, OP_PIXEL);
        drain_results();
        write_reg(CFG_IMAGE_HEIGHT, 48'd2);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'h00, OP_PIXEL);
        send_tick(8'hFF, OP_PIXEL);
        send_tick(8'h00, OP_PAD);
        send_tick(8'h00, OP_PAD);
        send_tick(8'h00, OP_PAD);
        drain_results();
    endtask

    // Width above the line store saturates, seen on the first results of the
    // flush; tallest height, partly streamed
    task automatic test_wide_and_tall();
        int sent;
        set_idle_phase(1);
        write_reg(CFG_IMAGE_WIDTH, 48'h7FF);
        write_reg(CFG_IMAGE_HEIGHT, 48'd1);
        write_reg(CFG_KERNEL_TOP, random_kernel_row(2));
        write_reg(CFG_KERNEL_MIDDLE, random_kernel_row(2));
        write_reg(CFG_KERNEL_BOTTOM, random_kernel_row(2));
        stream_frame(frame_width(), 4, 1'b0, sent);
        drain_results();
        set_idle_phase(2);
        write_reg(CFG_IMAGE_WIDTH, 48'd5);
        write_reg(CFG_IMAGE_HEIGHT, 48'hFFFF);
        write_reg(CFG_KERNEL_MIDDLE, random_kernel_row(0));
        stream_frame(30, 0, 1'b0, sent);
        drain_results();
    endtask

    // Mostly small random frames with random kernels, some cut short
    task automatic test_random_frames();
        int random_ticks;
        int frame_idx;
        int sent;
        int w;
        int h;
        bit need_geometry;
        random_ticks  = 0;
        frame_idx     = 0;
        need_geometry = 1'b1;
        while (random_ticks < RANDOM_ITEMS) begin
            drain_results();
            set_idle_phase(frame_idx % 4);
            if (need_geometry || $urandom_range(3) != 0) begin
                write_reg(CFG_IMAGE_WIDTH,
                          CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                               : $urandom_range(8, 0)));
                write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(6, 0)));
                need_geometry = 1'b0;
            end
            if ($urandom_range(2) == 0) begin
                write_reg(CFG_KERNEL_TOP, random_kernel_row($urandom_range(3)));
                write_reg(CFG_KERNEL_MIDDLE, random_kernel_row($urandom_range(3)));
                write_reg(CFG_KERNEL_BOTTOM, random_kernel_row($urandom_range(3)));
            end
            w = frame_width();
            h = frame_height();
            if ($urandom_range(11) == 0) begin
                stream_frame($urandom_range(w * h, 1), 0, 1'b1, sent);
                need_geometry = 1'b1;
            end else begin
                stream_frame(w * h, w + 1, 1'b1, sent);
            end
            random_ticks += sent;
            frame_idx++;
        end
    endtask

    // Receiver stalls
    always @(negedge clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk) begin
        t_pixel_result got;
        t_pixel_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.filtered   = res_if.filtered;
            got.overflow   = res_if.overflow;
            got.frame_last = res_if.frame_last;
            if (expected_pixels.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected result %0d: filtered=%0d overflow=%0b frame_last=%0b",
                    result_count, got.filtered, got.overflow, got.frame_last));
            end else begin
                want = expected_pixels.pop_front();
                if (got.filtered !== want.filtered || got.overflow !== want.overflow ||
                    got.frame_last !== want.frame_last)
                    note_mismatch($sformatf(
                        "result %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
                        result_count, want.filtered, want.overflow, want.frame_last,
                        got.filtered, got.overflow, got.frame_last));
            end
            result_count++;
        end
    end

    // Count cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int i;
        pix_if.valid     = 1'b0;
        pix_if.pixel     = '0;
        pix_if.operation = OP_PIXEL;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_IMAGE_WIDTH;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        rst_n            = 1'b0;
        quiet_cycles     = 0;
        mismatches       = 0;
        result_count     = 0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;

        // Model state after reset
        model_width     = RST_WIDTH;
        model_height    = RST_HEIGHT;
        model_kernel[0] = RST_KERNEL_TOP;
        model_kernel[1] = RST_KERNEL_MIDDLE;
        model_kernel[2] = RST_KERNEL_BOTTOM;
        for (i = 0; i < LINE_MAX; i++) begin
            row_delay1[i] = '0;
            row_delay2[i] = '0;
        end
        for (i = 0; i < 9; i++) tap_window[i / 3][i % 3] = '0;
        col_pos = 0;
        row_pos = 0;
        refresh_norm();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // hold off until the line store clearing pass is done
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);

        test_degenerate_sizes();
        test_small_frame();
        test_restart_and_flush();
        test_wide_and_tall();
        test_random_frames();
        drain_results();

        mismatches += expected_pixels.size();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[zero_padded_kernel_convolution.f]
design/zpkc_pkg.sv
design/zpkc_pix_if.sv
design/zpkc_res_if.sv
design/zpkc_cfg_if.sv
design/zpkc_tap_cell.sv
design/zpkc_div_cell.sv
design/zero_padded_kernel_convolution.sv
bench/tb_zero_padded_kernel_convolution.sv
